>>> hw/rtl/plic_pkg.sv
`default_nettype none

package plic_pkg;

    localparam int IdW    = 5;
    localparam int PrioW  = 3;
    localparam int OffW   = 22;
    localparam int DataW  = 32;
    localparam int NumCtx = 2;

    // transaction kinds
    localparam logic [1:0] FuncRead  = 2'd0;
    localparam logic [1:0] FuncWrite = 2'd1;
    localparam logic [1:0] FuncLine  = 2'd2;

    // address decode: pending word index, enable block offset[21:8],
    // context block offset[21:13], sub-offsets inside a context block
    localparam logic [19:0] PendWord  = 20'h00400;
    localparam logic [13:0] EnBaseHi  = 14'h0020;
    localparam logic [8:0]  CtxBaseHi = 9'h100;
    localparam logic [11:0] SubThr    = 12'h000;
    localparam logic [11:0] SubClaim  = 12'h004;

    typedef struct packed {
        logic [1:0]      func;
        logic [OffW-1:0] offset;
        logic [DataW-1:0] wdata;
        logic [IdW-1:0]  irq_id;
        logic            irq_level;
    } t_req;

    typedef struct packed {
        logic [DataW-1:0] read_data;
        logic [IdW-1:0]   mach_claimable;
        logic [IdW-1:0]   sup_claimable;
    } t_rsp;

    // best candidate so far, travels along the cell row
    typedef struct packed {
        logic [IdW-1:0]   id;
        logic [PrioW-1:0] prio;
    } t_best;

    // per-source status seen by one cell
    typedef struct packed {
        logic                           pend;
        logic [NumCtx-1:0]              en;
        logic [NumCtx-1:0]              clm;
        logic [NumCtx-1:0][PrioW-1:0]   thr;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/plic_if.sv
`default_nettype none

interface plic_req_if;
    logic          valid;
    logic          ready;
    plic_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface plic_rsp_if;
    logic          valid;
    logic          ready;
    plic_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/plic_cell.sv
`default_nettype none

module plic_cell #(
    parameter int CELL_ID = 1
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_prio_we,
    input  logic [plic_pkg::PrioW-1:0]                  i_prio_wdata,
    input  plic_pkg::t_cell_ctl                         i_ctl,
    input  plic_pkg::t_best [plic_pkg::NumCtx-1:0]      i_tok,
    output plic_pkg::t_best [plic_pkg::NumCtx-1:0]      o_tok,
    output logic [plic_pkg::PrioW-1:0]                  o_prio
);

    logic [plic_pkg::PrioW-1:0]             r_prio;
    logic [plic_pkg::PrioW-1:0]             n_prio;
    plic_pkg::t_best [plic_pkg::NumCtx-1:0] r_tok;
    plic_pkg::t_best [plic_pkg::NumCtx-1:0] n_tok;

    always_comb begin
        n_prio = i_prio_we ? i_prio_wdata : r_prio;
    end

    // take over the token when this source beats it; ties go to the higher id
    always_comb begin
        for (int c = 0; c < plic_pkg::NumCtx; c++) begin
            if (i_ctl.pend && i_ctl.en[c] && !i_ctl.clm[c] &&
                (r_prio > i_ctl.thr[c]) && (r_prio >= i_tok[c].prio)) begin
                n_tok[c].id   = plic_pkg::IdW'(CELL_ID);
                n_tok[c].prio = r_prio;
            end else begin
                n_tok[c] = i_tok[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio <= '0;
            r_tok  <= '0;
        end else begin
            r_prio <= n_prio;
            r_tok  <= n_tok;
        end
    end

    assign o_tok  = r_tok;
    assign o_prio = r_prio;

endmodule

`default_nettype wire

>>> hw/rtl/platform_interrupt_controller_unit.sv
// a result is loaded into the output register once the scan counter has walked the whole
//   cell row and the output register is free; the best-source token walks the row of
//   source cells one cell per cycle, and a new transaction is taken only in the idle state
// the output register lets the next transaction in while a result still waits
// reset (synchronous, active low) clears priorities, pending lines, enables,
//   thresholds, claimed marks, best-source ids and the output valid flag
`default_nettype none

module platform_interrupt_controller_unit #(
    parameter int NUM_SOURCES = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    plic_req_if.sink          i_req,
    plic_rsp_if.source        o_rsp
);

    localparam int CntW = $clog2(NUM_SOURCES + 1);

    plic_pkg::t_state r_state;
    plic_pkg::t_state n_state;
    logic [CntW-1:0]  r_cnt;
    logic [CntW-1:0]  n_cnt;

    logic [NUM_SOURCES:1]                                   r_pend;
    logic [NUM_SOURCES:1]                                   n_pend;
    logic [plic_pkg::NumCtx-1:0][plic_pkg::DataW-1:0]       r_en;
    logic [plic_pkg::NumCtx-1:0][plic_pkg::DataW-1:0]       n_en;
    logic [plic_pkg::NumCtx-1:0][plic_pkg::PrioW-1:0]       r_thr;
    logic [plic_pkg::NumCtx-1:0][plic_pkg::PrioW-1:0]       n_thr;
    logic [plic_pkg::NumCtx-1:0][NUM_SOURCES:1]             r_clm;
    logic [plic_pkg::NumCtx-1:0][NUM_SOURCES:1]             n_clm;
    logic [plic_pkg::NumCtx-1:0][plic_pkg::IdW-1:0]         r_best;

    logic [plic_pkg::DataW-1:0] r_rdata;
    logic [plic_pkg::DataW-1:0] n_rdata;
    logic                       r_out_valid;
    plic_pkg::t_rsp             r_rsp;

    plic_pkg::t_req req;
    logic           accept;
    logic           in_ready;
    logic           load;
    logic           scan_done;

    logic                       is_rd;
    logic                       is_wr;
    logic                       is_line;
    logic [plic_pkg::IdW-1:0]   widx;
    logic                       prio_hit;
    logic                       pend_hit;
    logic                       en_hit;
    logic                       en_ctx;
    logic                       en_word0;
    logic                       ctx_hit;
    logic                       ctx;
    logic [11:0]                sub;
    logic [plic_pkg::IdW-1:0]   done_id;

    logic [plic_pkg::NumCtx-1:0] claim_set;
    logic [plic_pkg::NumCtx-1:0] done_we;
    logic [plic_pkg::NumCtx-1:0] thr_we;
    logic [plic_pkg::NumCtx-1:0] en_we;

    plic_pkg::t_best [plic_pkg::NumCtx-1:0] w_tok  [0:NUM_SOURCES];
    logic [plic_pkg::PrioW-1:0]             w_prio [1:NUM_SOURCES];
    plic_pkg::t_cell_ctl                    w_ctl  [1:NUM_SOURCES];

    assign req    = i_req.data;
    assign accept = i_req.valid && in_ready;
    assign i_req.ready = in_ready;

    // address decode
    always_comb begin
        is_rd    = (req.func == plic_pkg::FuncRead);
        is_wr    = (req.func == plic_pkg::FuncWrite);
        is_line  = (req.func == plic_pkg::FuncLine);
        widx     = req.offset[6:2];
        prio_hit = (req.offset[21:7] == '0) && (widx != '0) &&
                   (widx <= plic_pkg::IdW'(NUM_SOURCES));
        pend_hit = (req.offset[21:2] == plic_pkg::PendWord);
        en_hit   = (req.offset[21:8] == plic_pkg::EnBaseHi);
        en_ctx   = req.offset[7];
        en_word0 = (req.offset[6:2] == '0);
        ctx_hit  = (req.offset[21:13] == plic_pkg::CtxBaseHi);
        ctx      = req.offset[12];
        sub      = req.offset[11:0];
        done_id  = req.wdata[plic_pkg::IdW-1:0];
    end

    always_comb begin
        for (int c = 0; c < plic_pkg::NumCtx; c++) begin
            claim_set[c] = accept && is_rd && ctx_hit && (ctx == 1'(c)) &&
                           (sub == plic_pkg::SubClaim) && (r_best[c] != '0);
            done_we[c]   = accept && is_wr && ctx_hit && (ctx == 1'(c)) &&
                           (sub == plic_pkg::SubClaim);
            thr_we[c]    = accept && is_wr && ctx_hit && (ctx == 1'(c)) &&
                           (sub == plic_pkg::SubThr);
            en_we[c]     = accept && is_wr && en_hit && (en_ctx == 1'(c)) && en_word0;
        end
    end

    // read data; a claim returns the best source of the state before the transaction
    always_comb begin
        n_rdata = '0;
        if (is_rd) begin
            if (prio_hit) begin
                n_rdata = plic_pkg::DataW'(w_prio[widx]);
            end else if (pend_hit) begin
                n_rdata = plic_pkg::DataW'({r_pend, 1'b0});
            end else if (en_hit) begin
                n_rdata = en_word0 ? r_en[en_ctx] : '0;
            end else if (ctx_hit) begin
                if (sub == plic_pkg::SubThr) begin
                    n_rdata = plic_pkg::DataW'(r_thr[ctx]);
                end else if (sub == plic_pkg::SubClaim) begin
                    n_rdata = plic_pkg::DataW'(r_best[ctx]);
                end
            end
        end
    end

    // state updates
    always_comb begin
        n_pend = r_pend;
        n_clm  = r_clm;
        for (int c = 0; c < plic_pkg::NumCtx; c++) begin
            n_en[c]  = en_we[c]  ? req.wdata : r_en[c];
            n_thr[c] = thr_we[c] ? req.wdata[plic_pkg::PrioW-1:0] : r_thr[c];
        end
        for (int k = 1; k <= NUM_SOURCES; k++) begin
            if (accept && is_line && (req.irq_id == plic_pkg::IdW'(k))) begin
                n_pend[k] = req.irq_level;
            end
            for (int c = 0; c < plic_pkg::NumCtx; c++) begin
                if (claim_set[c] && (r_best[c] == plic_pkg::IdW'(k))) begin
                    n_clm[c][k] = 1'b1;
                end
                if (done_we[c] && (done_id == plic_pkg::IdW'(k))) begin
                    n_clm[c][k] = 1'b0;
                end
            end
        end
    end

    // cell row
    assign w_tok[0] = '0;

    for (genvar k = 1; k <= NUM_SOURCES; k++) begin : g_cell
        assign w_ctl[k].pend = r_pend[k];
        assign w_ctl[k].en   = {r_en[1][k], r_en[0][k]};
        assign w_ctl[k].clm  = {r_clm[1][k], r_clm[0][k]};
        assign w_ctl[k].thr  = r_thr;

        plic_cell #(
            .CELL_ID (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_prio_we    (accept && is_wr && prio_hit &&
                           (widx == plic_pkg::IdW'(k))),
            .i_prio_wdata (req.wdata[plic_pkg::PrioW-1:0]),
            .i_ctl        (w_ctl[k]),
            .i_tok        (w_tok[k-1]),
            .o_tok        (w_tok[k]),
            .o_prio       (w_prio[k])
        );
    end

    // control
    assign scan_done = (r_cnt == CntW'(NUM_SOURCES));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plic_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = plic_pkg::ST_SCAN;
                end
            end
            plic_pkg::ST_SCAN: begin
                if (scan_done && (!r_out_valid || o_rsp.ready)) begin
                    n_state = plic_pkg::ST_IDLE;
                end
            end
            default: n_state = plic_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        load     = 1'b0;
        n_cnt    = r_cnt;
        unique case (r_state)
            plic_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                n_cnt    = '0;
            end
            plic_pkg::ST_SCAN: begin
                load = scan_done && (!r_out_valid || o_rsp.ready);
                if (!scan_done) begin
                    n_cnt = r_cnt + CntW'(1);
                end
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plic_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_pend      <= '0;
            r_en        <= '0;
            r_thr       <= '0;
            r_clm       <= '0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_en    <= n_en;
            r_thr   <= n_thr;
            r_clm   <= n_clm;
            if (load) begin
                for (int c = 0; c < plic_pkg::NumCtx; c++) begin
                    r_best[c] <= w_tok[NUM_SOURCES][c].id;
                end
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= n_rdata;
        end
        if (load) begin
            r_rsp.read_data      <= r_rdata;
            r_rsp.mach_claimable <= w_tok[NUM_SOURCES][0].id;
            r_rsp.sup_claimable  <= w_tok[NUM_SOURCES][1].id;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    // checks
    a_scan_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(NUM_SOURCES))
        else $error("scan counter ran past the cell row");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == plic_pkg::ST_SCAN) && (r_cnt == '0))
        else $error("accepted transaction did not start a scan");

    a_best_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plic_pkg::ST_IDLE) && (r_best[0] != '0) |-> r_en[0][r_best[0]])
        else $error("context 0 claimable source is not enabled");

    a_rsp_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_rsp.mach_claimable <= plic_pkg::IdW'(NUM_SOURCES)) &&
                        (r_rsp.sup_claimable <= plic_pkg::IdW'(NUM_SOURCES)))
        else $error("claimable id out of source range");

endmodule

`default_nettype wire
